// ----- rtl/akvt_pkg.sv -----
`default_nettype none

package akvt_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int KEY_BITS_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;

  localparam int CAP_W    = 5;
  localparam int STATUS_W = 2;
  localparam int RDATA_W  = 32;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    CMD_GET    = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_FIND   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_DUP  = 2'd2,
    ST_FULL = 2'd3
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch request item
    logic lookup;   // compare all slots, update table
    logic load;     // move result into output register
  } ctl_t;

endpackage

`default_nettype wire

// ----- rtl/akvt_ctrl.sv -----
`default_nettype none

module akvt_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output akvt_pkg::ctl_t   ctl_o
);
  import akvt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_LOAD = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;
  logic   accept;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    ctl_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
      end
      S_CMP: begin
        ctl_o.lookup = 1'b1;
        state_d      = S_LOAD;
      end
      S_LOAD: begin
        in_ready_o = slot_free;
        if (slot_free) begin
          ctl_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    accept = in_valid_i && in_ready_o;
    if (accept) begin
      ctl_o.capture = 1'b1;
      state_d       = S_CMP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- rtl/akvt_datapath.sv -----
`default_nettype none

module akvt_datapath #(
  parameter int ENTRIES    = akvt_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = akvt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = akvt_pkg::VALUE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire akvt_pkg::ctl_t                ctl_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [akvt_pkg::CAP_W-1:0]    cfg_wdata_i,
  input  wire logic [1:0]                    cmd_i,
  input  wire logic [KEY_BITS-1:0]           key_i,
  input  wire logic [VALUE_BITS-1:0]         value_i,
  output logic [akvt_pkg::STATUS_W-1:0]      status_o,
  output logic [akvt_pkg::RDATA_W-1:0]       read_value_o,
  output logic [akvt_pkg::SLOT_W-1:0]        slot_index_o,
  output logic [akvt_pkg::COUNT_W-1:0]       pair_count_o
);
  import akvt_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  function automatic logic [IDX_W-1:0] lowest(input logic [ENTRIES-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (v[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

  // configuration
  logic [CAP_W-1:0]      cap_q;

  // request
  cmd_e                  cmd_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;

  // table
  logic [KEY_BITS-1:0]   key_store_q [ENTRIES];
  logic [VALUE_BITS-1:0] val_mem     [ENTRIES];
  logic [ENTRIES-1:0]    slot_valid_q;
  logic [CNT_W-1:0]      count_q;
  logic [VALUE_BITS-1:0] rdata_q;

  // lookup result
  status_e               res_status_q, res_status_d;
  logic [IDX_W-1:0]      res_slot_q, res_slot_d;
  logic                  res_rd_q, res_rd_d;

  // output register
  status_e               status_q;
  logic [RDATA_W-1:0]    read_value_q;
  logic [SLOT_W-1:0]     slot_index_q;
  logic [COUNT_W-1:0]    pair_count_q;

  logic [ENTRIES-1:0]    hit_vec, free_vec;
  logic [CMP_W-1:0]      cap_ext, slots_n;
  logic                  key_zero, any_hit, is_full;
  logic [IDX_W-1:0]      hit_idx, free_idx;
  logic                  do_ins, do_del;

  logic [RDATA_W+VALUE_BITS-1:0] rdata_ext;
  logic [SLOT_W+IDX_W-1:0]       slot_ext;
  logic [COUNT_W+CNT_W-1:0]      count_ext;

  assign cap_ext  = CMP_W'(cap_q);
  assign slots_n  = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
  assign key_zero = (key_q == '0);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i]  = slot_valid_q[i] && (CMP_W'(i) < cap_ext) &&
                    (key_store_q[i] == key_q) && !key_zero;
      free_vec[i] = !slot_valid_q[i] && (CMP_W'(i) < cap_ext);
    end
  end

  assign any_hit  = |hit_vec;
  assign hit_idx  = lowest(hit_vec);
  assign free_idx = lowest(free_vec);
  assign is_full  = key_zero || (CMP_W'(count_q) >= slots_n) || !(|free_vec);

  always_comb begin
    res_status_d = ST_MISS;
    res_slot_d   = '0;
    res_rd_d     = 1'b0;
    do_ins       = 1'b0;
    do_del       = 1'b0;
    unique case (cmd_q)
      CMD_INSERT: begin
        if (is_full) begin
          res_status_d = ST_FULL;
        end else if (any_hit) begin
          res_status_d = ST_DUP;
          res_slot_d   = hit_idx;
        end else begin
          res_status_d = ST_OK;
          res_slot_d   = free_idx;
          do_ins       = 1'b1;
        end
      end
      CMD_GET, CMD_FIND, CMD_DELETE: begin
        if (any_hit) begin
          res_status_d = ST_OK;
          res_slot_d   = hit_idx;
          res_rd_d     = (cmd_q != CMD_FIND);
          do_del       = (cmd_q == CMD_DELETE);
        end
      end
      default: begin
        res_status_d = ST_MISS;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q        <= CAP_RESET;
      slot_valid_q <= '0;
      count_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (ctl_i.lookup) begin
        if (do_ins) begin
          slot_valid_q[free_idx] <= 1'b1;
          count_q                <= count_q + CNT_W'(1);
        end
        if (do_del) begin
          slot_valid_q[hit_idx] <= 1'b0;
          if (count_q != '0) count_q <= count_q - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q <= cmd_e'(cmd_i);
      key_q <= key_i;
      val_q <= value_i;
    end
    if (ctl_i.lookup) begin
      if (do_ins) key_store_q[free_idx] <= key_q;
      res_status_q <= res_status_d;
      res_slot_q   <= res_slot_d;
      res_rd_q     <= res_rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.lookup) begin
      if (do_ins) val_mem[free_idx] <= val_q;
      rdata_q <= val_mem[hit_idx];
    end
  end

  assign rdata_ext = {{RDATA_W{1'b0}}, rdata_q};
  assign slot_ext  = {{SLOT_W{1'b0}}, res_slot_q};
  assign count_ext = {{COUNT_W{1'b0}}, count_q};

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      status_q     <= res_status_q;
      read_value_q <= res_rd_q ? rdata_ext[RDATA_W-1:0] : '0;
      slot_index_q <= slot_ext[SLOT_W-1:0];
      pair_count_q <= count_ext[COUNT_W-1:0];
    end
  end

  assign status_o     = status_q;
  assign read_value_o = read_value_q;
  assign slot_index_o = slot_index_q;
  assign pair_count_o = pair_count_q;

endmodule

`default_nettype wire

// ----- rtl/associative_key_value_table.sv -----
// Fully associative key/value table.
// Request channel (in_valid_i/in_ready_o): cmd_i (get, insert, delete, find),
// key_i and value_i. Result channel (out_valid_o/out_ready_i): status_o,
// read_value_o, slot_index_o and pair_count_o, one result per request, in order.
// Each request runs through the controller states in order: the accepting cycle
// latches the request, the compare state compares the key against every slot at
// once and updates the table, and the load state moves the result into the output
// register. A new request is accepted in the load state, but not in the compare state.
// A result waiting in the output register does not block the next lookup; a
// stalled receiver holds the block only when a second result is ready to load.
// cfg_we_i/cfg_wdata_i writes the number of slots in use; write it only while
// the block is idle.
// Reset empties the table, clears the pair count and sets the capacity to 16.
`default_nettype none

module associative_key_value_table #(
  parameter int ENTRIES    = akvt_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = akvt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = akvt_pkg::VALUE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [akvt_pkg::CAP_W-1:0]    cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    cmd_i,
  input  wire logic [KEY_BITS-1:0]           key_i,
  input  wire logic [VALUE_BITS-1:0]         value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [akvt_pkg::STATUS_W-1:0]      status_o,
  output logic [akvt_pkg::RDATA_W-1:0]       read_value_o,
  output logic [akvt_pkg::SLOT_W-1:0]        slot_index_o,
  output logic [akvt_pkg::COUNT_W-1:0]       pair_count_o
);
  import akvt_pkg::*;

  ctl_t ctl;

  akvt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctl_o       (ctl)
  );

  akvt_datapath #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .status_o     (status_o),
    .read_value_o (read_value_o),
    .slot_index_o (slot_index_o),
    .pair_count_o (pair_count_o)
  );

  // the lookup state always follows an accepted item
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted during lookup");

  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_MISS) |-> (read_value_o == '0) && (slot_index_o == '0))
    else $error("miss result carries data");

  a_nok_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (read_value_o == '0))
    else $error("failed request returns a value");

  a_full_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> (slot_index_o == '0))
    else $error("full result carries a slot");

endmodule

`default_nettype wire

// ----- bench/associative_key_value_table_tb.sv -----
`timescale 1ns / 100ps

module associative_key_value_table_tb;
  import akvt_pkg::*;

  typedef struct packed {
    status_e            status;
    logic [RDATA_W-1:0] read_value;
    logic [SLOT_W-1:0]  slot_index;
    logic [COUNT_W-1:0] pair_count;
  } lookup_result_t;

  typedef struct {
    bit             is_cfg;
    logic [4:0]     cap;
    cmd_e           cmd;
    logic [63:0]    key;
    logic [31:0]    value;
    bit             typed;
    lookup_result_t want;
  } plan_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CAP_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] cmd_i = CMD_GET;
  logic [63:0] key_i = '0;
  logic [31:0] value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [RDATA_W-1:0] read_value_o;
  logic [SLOT_W-1:0] slot_index_o;
  logic [COUNT_W-1:0] pair_count_o;

  // known answer riding along with the current item
  bit cur_typed = 1'b0;
  lookup_result_t cur_want = '0;

  // shadow table
  logic [63:0] tbl_key [16];
  logic [31:0] tbl_value [16];
  bit tbl_used [16];
  int tbl_pairs = 0;
  logic [4:0] capacity = CAP_RESET;

  lookup_result_t pending_results [$];
  plan_row_t plan [$];
  logic [63:0] key_pool [24];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int mismatches = 0;
  int requests = 0;
  int cap_writes = 0;
  int status_tally [4] = '{0, 0, 0, 0};

  associative_key_value_table dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .read_value_o (read_value_o),
    .slot_index_o (slot_index_o),
    .pair_count_o (pair_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Timeout at %0t", $time);
    $display("Some tests failed");
    $finish;
  end

  function automatic int slots_visible();
    return (capacity > 16) ? 16 : int'(capacity);
  endfunction

  function automatic lookup_result_t predict_request(cmd_e c, logic [63:0] k, logic [31:0] v);
    lookup_result_t r;
    int lim;
    int hit;
    int spare;
    int i;
    lim = slots_visible();
    hit = -1;
    spare = -1;
    for (i = 0; i < lim; i++) begin
      if (hit < 0 && k != 0 && tbl_used[i] && tbl_key[i] == k) hit = i;
      if (spare < 0 && !tbl_used[i]) spare = i;
    end
    r = '0;
    r.status = ST_MISS;
    if (c == CMD_INSERT) begin
      if (k == 0 || tbl_pairs >= lim || spare < 0) begin
        r.status = ST_FULL;
      end else if (hit >= 0) begin
        r.status = ST_DUP;
        r.slot_index = hit[3:0];
      end else begin
        tbl_key[spare] = k;
        tbl_value[spare] = v;
        tbl_used[spare] = 1'b1;
        tbl_pairs++;
        r.status = ST_OK;
        r.slot_index = spare[3:0];
      end
    end else if (hit >= 0) begin
      r.status = ST_OK;
      r.slot_index = hit[3:0];
      if (c != CMD_FIND) r.read_value = tbl_value[hit];
      if (c == CMD_DELETE) begin
        tbl_used[hit] = 1'b0;
        if (tbl_pairs > 0) tbl_pairs--;
      end
    end
    r.pair_count = tbl_pairs[4:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    lookup_result_t p;
    lookup_result_t w;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        p = predict_request(cmd_e'(cmd_i), key_i, value_i);
        pending_results.push_back(cur_typed ? cur_want : p);
        status_tally[p.status]++;
        requests++;
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with no request outstanding", $time);
          mismatches++;
        end else begin
          w = pending_results.pop_front();
          if (status_o !== w.status) begin
            $display("%0t: status expected %0d got %0d", $time, w.status, status_o);
            mismatches++;
          end
          if (read_value_o !== w.read_value) begin
            $display("%0t: read_value expected %h got %h", $time, w.read_value,
                     read_value_o);
            mismatches++;
          end
          if (slot_index_o !== w.slot_index) begin
            $display("%0t: slot_index expected %0d got %0d", $time, w.slot_index,
                     slot_index_o);
            mismatches++;
          end
          if (pair_count_o !== w.pair_count) begin
            $display("%0t: pair_count expected %0d got %0d", $time, w.pair_count,
                     pair_count_o);
            mismatches++;
          end
        end
      end
    end
  end

  function automatic plan_row_t mk_req(cmd_e c, logic [63:0] k, logic [31:0] v, bit typed,
                                       status_e st, logic [31:0] rd, logic [3:0] slot,
                                       logic [4:0] pairs);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.cap = '0;
    r.cmd = c;
    r.key = k;
    r.value = v;
    r.typed = typed;
    r.want.status = st;
    r.want.read_value = rd;
    r.want.slot_index = slot;
    r.want.pair_count = pairs;
    return r;
  endfunction

  function automatic plan_row_t mk_cfg(logic [4:0] cap);
    plan_row_t r;
    r = mk_req(CMD_GET, '0, '0, 1'b0, ST_OK, '0, '0, '0);
    r.is_cfg = 1'b1;
    r.cap = cap;
    return r;
  endfunction

  task automatic send_item(cmd_e c, logic [63:0] k, logic [31:0] v, bit typed,
                           lookup_result_t want);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_i <= c;
    key_i <= k;
    value_i <= v;
    cur_typed <= typed;
    cur_want <= want;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [4:0] cap);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    capacity = cap;
    cap_writes++;
  endtask

  initial begin
    logic [63:0] ones;
    logic [63:0] msb;
    logic [63:0] alt;
    logic [63:0] k;
    logic [31:0] v;
    int blk;
    int n;
    int lim;
    int span;
    int r;
    cmd_e c;
    logic [4:0] caps [12];

    caps = '{5'd16, 5'd4, 5'd1, 5'd10, 5'd16, 5'd2, 5'd0, 5'd20, 5'd7, 5'd16, 5'd3, 5'd31};
    ones = '1;
    msb = 64'h8000_0000_0000_0000;
    alt = 64'h5555_5555_5555_5555;
    for (n = 0; n < 16; n++) tbl_used[n] = 1'b0;
    key_pool[0] = ones;
    key_pool[1] = 64'd1;
    key_pool[2] = msb;
    for (n = 3; n < 24; n++) key_pool[n] = {$urandom, $urandom};

    plan.push_back(mk_req(CMD_GET, 64'd1, 32'd0, 1, ST_MISS, 32'd0, 4'd0, 5'd0));
    plan.push_back(mk_req(CMD_INSERT, 64'd0, 32'd7, 1, ST_FULL, 32'd0, 4'd0, 5'd0));
    plan.push_back(mk_req(CMD_INSERT, ones, 32'hFFFF_FFFF, 1, ST_OK, 32'd0, 4'd0, 5'd1));
    plan.push_back(mk_req(CMD_INSERT, 64'd1, 32'd0, 1, ST_OK, 32'd0, 4'd1, 5'd2));
    plan.push_back(mk_req(CMD_INSERT, ones, 32'd5, 1, ST_DUP, 32'd0, 4'd0, 5'd2));
    plan.push_back(mk_req(CMD_GET, ones, 32'd0, 1, ST_OK, 32'hFFFF_FFFF, 4'd0, 5'd2));
    plan.push_back(mk_req(CMD_FIND, 64'd1, 32'd0, 1, ST_OK, 32'd0, 4'd1, 5'd2));
    plan.push_back(mk_req(CMD_GET, 64'd0, 32'd0, 1, ST_MISS, 32'd0, 4'd0, 5'd2));
    plan.push_back(mk_req(CMD_DELETE, 64'd0, 32'd0, 1, ST_MISS, 32'd0, 4'd0, 5'd2));
    plan.push_back(mk_req(CMD_FIND, 64'd0, 32'd0, 1, ST_MISS, 32'd0, 4'd0, 5'd2));
    plan.push_back(mk_req(CMD_DELETE, ones, 32'd0, 1, ST_OK, 32'hFFFF_FFFF, 4'd0, 5'd1));
    plan.push_back(mk_req(CMD_DELETE, ones, 32'd0, 1, ST_MISS, 32'd0, 4'd0, 5'd1));
    plan.push_back(mk_req(CMD_INSERT, msb, 32'h8000_0000, 1, ST_OK, 32'd0, 4'd0, 5'd2));
    plan.push_back(mk_req(CMD_INSERT, alt, 32'hA5A5_A5A5, 0, ST_OK, 32'd0, 4'd0, 5'd0));
    plan.push_back(mk_req(CMD_DELETE, 64'd1, 32'd0, 1, ST_OK, 32'd0, 4'd1, 5'd2));
    // capacity lowered: slot 2 still counts but is hidden
    plan.push_back(mk_cfg(5'd2));
    plan.push_back(mk_req(CMD_FIND, alt, 32'd0, 1, ST_MISS, 32'd0, 4'd0, 5'd2));
    plan.push_back(mk_req(CMD_INSERT, 64'd3, 32'd3, 1, ST_FULL, 32'd0, 4'd0, 5'd2));
    plan.push_back(mk_cfg(5'd0));
    plan.push_back(mk_req(CMD_GET, msb, 32'd0, 1, ST_MISS, 32'd0, 4'd0, 5'd2));
    plan.push_back(mk_req(CMD_INSERT, 64'd7, 32'd7, 1, ST_FULL, 32'd0, 4'd0, 5'd2));
    plan.push_back(mk_cfg(5'd16));
    plan.push_back(mk_req(CMD_FIND, alt, 32'd0, 0, ST_OK, 32'd0, 4'd0, 5'd0));
    plan.push_back(mk_req(CMD_INSERT, 64'd9, 32'd9, 0, ST_OK, 32'd0, 4'd0, 5'd0));
    // full check wins over duplicate check
    plan.push_back(mk_cfg(5'd1));
    plan.push_back(mk_req(CMD_INSERT, msb, 32'd1, 1, ST_FULL, 32'd0, 4'd0, 5'd3));
    plan.push_back(mk_req(CMD_GET, msb, 32'd0, 1, ST_OK, 32'h8000_0000, 4'd0, 5'd3));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle_pct = 22;
    rx_idle_pct = 84;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_capacity(plan[i].cap);
      end else begin
        send_item(plan[i].cmd, plan[i].key, plan[i].value, plan[i].typed, plan[i].want);
      end
    end

    for (blk = 0; blk < 12; blk++) begin
      drain();
      case (blk / 4)
        0: begin
          tx_idle_pct = 22;
          rx_idle_pct = 84;
        end
        1: begin
          tx_idle_pct = 84;
          rx_idle_pct = 22;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      write_capacity(caps[blk]);
      lim = slots_visible();
      span = (lim == 0) ? 3 : ((lim + 5 > 23) ? 23 : lim + 5);
      for (n = 0; n < 38; n++) begin
        r = $urandom_range(99);
        if (r < 35) c = CMD_INSERT;
        else if (r < 60) c = CMD_DELETE;
        else if (r < 80) c = CMD_GET;
        else c = CMD_FIND;
        r = $urandom_range(99);
        if (r < 5) k = '0;
        else if (r < 15) k = {$urandom, $urandom};
        else k = key_pool[$urandom_range(span)];
        r = $urandom_range(9);
        if (r == 0) v = '0;
        else if (r == 1) v = '1;
        else v = $urandom;
        send_item(c, k, v, 1'b0, '0);
      end
    end

    drain();
    $display("Covered %0d requests: %0d hits or stores, %0d misses, %0d duplicates, %0d refusals",
             requests, status_tally[ST_OK], status_tally[ST_MISS], status_tally[ST_DUP],
             status_tally[ST_FULL]);
    $display("Capacity written %0d times (0, 1, 16 and above), under three stall patterns",
             cap_writes);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- associative_key_value_table.f -----
rtl/akvt_pkg.sv
rtl/akvt_ctrl.sv
rtl/akvt_datapath.sv
rtl/associative_key_value_table.sv
bench/associative_key_value_table_tb.sv
